// ----- sv/dorq_pkg.sv -----
package dorq_pkg;

  // Field widths of one item and one result.
  localparam int FUNC_W   = 2;
  localparam int TASK_W   = 8;
  localparam int DL_W     = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // One queue entry as stored in the slot memory: deadline above task.
  localparam int ENTRY_W  = DL_W + TASK_W;

  // Default number of queue slots.
  localparam int DORQ_CAPACITY = 16;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

endpackage

// ----- sv/dorq_ram.sv -----
module dorq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/deadline_ordered_ready_queue.sv -----
// An item that needs no walk (insert into an empty or full queue, any
// operation on an empty queue) gives its result strobe in the cycle after accept.
// Extract, remove and query walk the slot memory head first, one slot a cycle.
// Insert walks from the tail.
// busy is low again in the cycle the result strobe shows; the receiver cannot stall.
// Reset clears the entry count and control state; the slot memory is not cleared.
module deadline_ordered_ready_queue #(
  parameter int CAPACITY = dorq_pkg::DORQ_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dorq_pkg::FUNC_W-1:0]    in_func,
  input  logic [dorq_pkg::TASK_W-1:0]    in_task_id,
  input  logic [dorq_pkg::DL_W-1:0]      in_deadline,
  output logic                           out_valid,
  output logic [dorq_pkg::STATUS_W-1:0]  out_status,
  output logic [dorq_pkg::TASK_W-1:0]    out_task,
  output logic [dorq_pkg::DL_W-1:0]      out_deadline,
  output logic                           out_present,
  output logic [dorq_pkg::OCC_W-1:0]     out_occupancy
);

  import dorq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Controller states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UP   = 2'd1;
  localparam logic [1:0] ST_DN   = 2'd2;
  localparam logic [1:0] ST_HEAD = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [FUNC_W-1:0]   op_r;
  logic [TASK_W-1:0]   id_r;
  logic [DL_W-1:0]     dl_r;
  logic                found_r, found_nxt;
  logic [ENTRY_W-1:0]  hit_r;
  logic                hit_load;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [TASK_W-1:0]   out_task_r, out_task_nxt;
  logic [DL_W-1:0]     out_dl_r, out_dl_nxt;
  logic                out_present_r, out_present_nxt;
  logic [OCC_W-1:0]    out_occ_r;

  logic                accept;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [IDX_W-1:0]    rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  logic [DL_W-1:0]     rd_dl;
  logic [TASK_W-1:0]   rd_task;
  logic                last;
  logic                match;

  dorq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept  = start && (state_r == ST_IDLE);
  assign rd_dl   = rd_data[ENTRY_W-1:TASK_W];
  assign rd_task = rd_data[TASK_W-1:0];
  assign last    = (idx_r == IDX_W'(cnt_r - 1'b1));
  assign match   = !found_r && ((op_r == FUNC_EXTRACT) || (rd_task == id_r));

  // Walk controller: the data read for slot idx_r arrives in the cycle after
  // the read was issued, so one slot is handled per cycle.
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    found_nxt       = found_r;
    hit_load        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = idx_r;
    wr_data         = rd_data;
    rd_addr         = idx_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = STATUS_OK;
    out_task_nxt    = '0;
    out_dl_nxt      = '0;
    out_present_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          found_nxt = 1'b0;
          if (cnt_r == CNT_W'(0)) begin
            // Empty queue: insert lands in the head slot, others answer at once.
            out_valid_nxt = 1'b1;
            case (in_func)
              FUNC_INSERT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {in_deadline, in_task_id};
                cnt_nxt = cnt_r + 1'b1;
              end
              FUNC_EXTRACT: out_status_nxt = STATUS_EMPTY;
              FUNC_REMOVE:  out_status_nxt = STATUS_NOTFOUND;
              default:      out_status_nxt = STATUS_OK;
            endcase
          end else if (in_func == FUNC_INSERT) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_FULL;
            end else begin
              // Start at the tail and shift later deadlines up by one slot.
              idx_nxt   = IDX_W'(cnt_r - 1'b1);
              rd_addr   = idx_nxt;
              state_nxt = ST_DN;
            end
          end else begin
            idx_nxt   = '0;
            rd_addr   = '0;
            state_nxt = ST_UP;
          end
        end
      end

      ST_UP: begin
        // Once the target is found, every later slot moves down by one.
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(idx_r - 1'b1);
          wr_data = rd_data;
        end
        if (match) begin
          found_nxt = 1'b1;
          hit_load  = 1'b1;
        end
        if ((op_r == FUNC_QUERY) && match) begin
          out_valid_nxt   = 1'b1;
          out_present_nxt = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (op_r == FUNC_QUERY) begin
            out_status_nxt = STATUS_OK;
          end else if (found_r || match) begin
            cnt_nxt = cnt_r - 1'b1;
            if (op_r == FUNC_EXTRACT) begin
              out_task_nxt = match ? rd_task : hit_r[TASK_W-1:0];
              out_dl_nxt   = match ? rd_dl : hit_r[ENTRY_W-1:TASK_W];
            end
          end else begin
            out_status_nxt = STATUS_NOTFOUND;
          end
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
          rd_addr = idx_nxt;
        end
      end

      ST_DN: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(idx_r + 1'b1);
        if (rd_dl > dl_r) begin
          // Later deadline: move it up and keep walking toward the head.
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = ST_HEAD;
          end else begin
            idx_nxt = IDX_W'(idx_r - 1'b1);
            rd_addr = idx_nxt;
          end
        end else begin
          // Equal or earlier deadline: the new task goes right behind it.
          wr_data       = {dl_r, id_r};
          cnt_nxt       = cnt_r + 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_HEAD: begin
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data       = {dl_r, id_r};
        cnt_nxt       = cnt_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item fields, walk index and result payload.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      op_r <= in_func;
      id_r <= in_task_id;
      dl_r <= in_deadline;
    end
    if (hit_load) begin
      hit_r <= rd_data;
    end
    out_status_r  <= out_status_nxt;
    out_task_r    <= out_task_nxt;
    out_dl_r      <= out_dl_nxt;
    out_present_r <= out_present_nxt;
    out_occ_r     <= OCC_W'(cnt_nxt);
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_task      = out_task_r;
  assign out_deadline  = out_dl_r;
  assign out_present   = out_present_r;
  assign out_occupancy = out_occ_r;

  // The entry count never exceeds the number of slots.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A result is only shown once the walk has ended.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result shown while walking");

  // Insert into a full queue is refused in the next cycle.
  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == FUNC_INSERT) && (cnt_r == CNT_W'(CAPACITY)))
    |=> (out_valid_r && (out_status_r == STATUS_FULL)))
    else $error("insert into full queue not refused");

  // The slot memory is only written by a walk or by an insert into an empty queue.
  a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (state_r == ST_IDLE)) |-> (accept && (cnt_r == CNT_W'(0))))
    else $error("stray slot write");

  // An empty report always comes with zero occupancy.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STATUS_EMPTY)) |-> (out_occ_r == '0))
    else $error("empty status with nonzero occupancy");

endmodule

// ----- dv/tb_deadline_ordered_ready_queue.sv -----
module tb_deadline_ordered_ready_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import dorq_pkg::*;

  localparam int QUEUE_DEPTH = DORQ_CAPACITY;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] task_id;
    logic [DL_W-1:0]   deadline;
    logic              drain;
  } sched_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   task_id;
    logic [DL_W-1:0]     deadline;
    logic                present;
    logic [OCC_W-1:0]    occupancy;
  } sched_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [FUNC_W-1:0] in_func = '0;
  logic [TASK_W-1:0] in_task_id = '0;
  logic [DL_W-1:0] in_deadline = '0;
  logic busy;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [TASK_W-1:0] out_task;
  logic [DL_W-1:0] out_deadline;
  logic out_present;
  logic [OCC_W-1:0] out_occupancy;

  // Shadow copy of the ready queue, head at index zero.
  logic [DL_W-1:0] shadow_deadline [QUEUE_DEPTH];
  logic [TASK_W-1:0] shadow_task [QUEUE_DEPTH];
  int shadow_count = 0;

  sched_req_t pending_ops[$];
  sched_resp_t expected_resp[$];
  logic took = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  deadline_ordered_ready_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_task_id(in_task_id),
    .in_deadline(in_deadline),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_task(out_task),
    .out_deadline(out_deadline),
    .out_present(out_present),
    .out_occupancy(out_occupancy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Position of the task nearest the head, or -1 when it is not queued.
  function automatic int find_queued(logic [TASK_W-1:0] id);
    int i;
    for (i = 0; i < shadow_count; i++) begin
      if (shadow_task[i] == id) return i;
    end
    return -1;
  endfunction

  // Close the gap left by the entry at pos.
  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < shadow_count; i++) begin
      shadow_deadline[i] = shadow_deadline[i + 1];
      shadow_task[i] = shadow_task[i + 1];
    end
    shadow_count--;
  endfunction

  // Apply one scheduler operation to the shadow queue and return its result.
  function automatic sched_resp_t predict_sched_op(sched_req_t req);
    sched_resp_t r;
    int pos;
    int i;
    r = '0;
    case (req.func)
      FUNC_INSERT: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          // Ties go behind every queued entry with the same deadline.
          pos = 0;
          while (pos < shadow_count && shadow_deadline[pos] <= req.deadline) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_deadline[i] = shadow_deadline[i - 1];
            shadow_task[i] = shadow_task[i - 1];
          end
          shadow_deadline[pos] = req.deadline;
          shadow_task[pos] = req.task_id;
          shadow_count++;
        end
      end
      FUNC_EXTRACT: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.task_id = shadow_task[0];
          r.deadline = shadow_deadline[0];
          drop_entry(0);
        end
      end
      FUNC_REMOVE: begin
        pos = find_queued(req.task_id);
        if (pos < 0) r.status = STATUS_NOTFOUND;
        else drop_entry(pos);
      end
      default: begin
        r.present = (find_queued(req.task_id) >= 0);
      end
    endcase
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  function automatic void push_op(logic [FUNC_W-1:0] func, logic [TASK_W-1:0] id,
                                  logic [DL_W-1:0] dl, logic drain);
    sched_req_t req;
    req.func = func;
    req.task_id = id;
    req.deadline = dl;
    req.drain = drain;
    pending_ops.push_back(req);
  endfunction

  // Random operation; insert_pct steers the queue toward full or empty.
  function automatic sched_req_t random_op(int insert_pct, logic drain);
    sched_req_t req;
    if ($urandom_range(99) < insert_pct) req.func = FUNC_INSERT;
    else req.func = FUNC_EXTRACT + FUNC_W'($urandom_range(2));
    // A small pool of identifiers makes queries and removes hit often.
    if ($urandom_range(3) == 0) req.task_id = TASK_W'($urandom_range(255));
    else req.task_id = TASK_W'($urandom_range(7));
    case ($urandom_range(3))
      0: req.deadline = $urandom();
      1: req.deadline = DL_W'($urandom_range(15));
      2: req.deadline = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3)
                                         : DL_W'($urandom_range(3));
      default: req.deadline = DL_W'($urandom_range(1000));
    endcase
    req.drain = drain;
    return req;
  endfunction

  function automatic void note_fault(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Driver: offers items at the falling edge in bursts, separated by gaps that may be empty.
  always @(negedge clk) begin
    sched_req_t nxt;
    logic go;
    nxt.func = in_func;
    nxt.task_id = in_task_id;
    nxt.deadline = in_deadline;
    nxt.drain = 1'b0;
    go = start;
    if (!rst_n) begin
      go = 1'b0;
    end else if (!(start && !took)) begin
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].drain && expected_resp.size() != 0)) begin
        nxt = pending_ops.pop_front();
        go = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    start <= go;
    in_func <= nxt.func;
    in_task_id <= nxt.task_id;
    in_deadline <= nxt.deadline;
  end

  // Monitor: checks each result against the oldest prediction, then
  // predicts the item accepted at this edge.
  always @(posedge clk) begin
    sched_resp_t got;
    sched_resp_t want;
    sched_req_t req;
    took <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_status, out_task, out_deadline, out_present, out_occupancy};
        if (expected_resp.size() == 0) begin
          note_fault($sformatf("result with none pending: status=%0d task=%0d dl=%h",
                               got.status, got.task_id, got.deadline));
        end else begin
          want = expected_resp.pop_front();
          if (got.status !== want.status || got.task_id !== want.task_id ||
              got.deadline !== want.deadline || got.present !== want.present ||
              got.occupancy !== want.occupancy) begin
            note_fault($sformatf({"mismatch: status %0d/%0d task %0d/%0d dl %h/%h ",
                                  "present %0d/%0d occ %0d/%0d (expected/actual)"},
                                 want.status, got.status, want.task_id, got.task_id,
                                 want.deadline, got.deadline, want.present, got.present,
                                 want.occupancy, got.occupancy));
          end
        end
      end
      if (start && !busy) begin
        req.func = in_func;
        req.task_id = in_task_id;
        req.deadline = in_deadline;
        req.drain = 1'b0;
        expected_resp.push_back(predict_sched_op(req));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int made;
    int seg_len;
    int insert_pct;
    int seg_idx;
    int k;

    // Directed: empty queue cases, extremes, ties, duplicates, full queue.
    push_op(FUNC_EXTRACT, 8'd0, 32'd0, 1'b0);
    push_op(FUNC_REMOVE, 8'd5, 32'd0, 1'b0);
    push_op(FUNC_QUERY, 8'd5, 32'hFFFF_FFFF, 1'b0);
    push_op(FUNC_INSERT, 8'd0, 32'hFFFF_FFFF, 1'b0);
    push_op(FUNC_INSERT, 8'hFF, 32'd0, 1'b0);
    push_op(FUNC_INSERT, 8'd7, 32'd100, 1'b0);
    push_op(FUNC_INSERT, 8'd8, 32'd100, 1'b0);
    push_op(FUNC_INSERT, 8'd7, 32'd100, 1'b0);
    for (k = 0; k < QUEUE_DEPTH - 5; k++) begin
      push_op(FUNC_INSERT, TASK_W'(16 + k), DL_W'(50 * k) ^ 32'h5555_0000, 1'b0);
    end
    push_op(FUNC_INSERT, 8'd99, 32'd1, 1'b1);
    push_op(FUNC_QUERY, 8'd7, 32'd0, 1'b0);
    push_op(FUNC_REMOVE, 8'd7, 32'd0, 1'b0);
    push_op(FUNC_REMOVE, 8'd200, 32'd0, 1'b0);
    push_op(FUNC_EXTRACT, 8'd0, 32'd0, 1'b0);
    push_op(FUNC_QUERY, 8'd200, 32'd0, 1'b0);

    // Random: segments that lean toward filling or draining the queue.
    made = 0;
    seg_idx = 0;
    while (made < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(3))
        0: insert_pct = 20;
        1: insert_pct = 50;
        2: insert_pct = 80;
        default: insert_pct = 95;
      endcase
      for (k = 0; k < seg_len; k++) begin
        pending_ops.push_back(random_op(insert_pct, (k == 0) && (seg_idx % 5 == 4)));
      end
      made += seg_len;
      seg_idx++;
    end

    // Reset.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all items to be taken and all results to arrive.
    while (pending_ops.size() != 0 || start || expected_resp.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
